// ----- rtl/debounced_key_report_builder_macros.svh -----
// assertion macros shared by the report builder checker
// no dependencies; include by bare file name
`ifndef DEBOUNCED_KEY_REPORT_BUILDER_MACROS_SVH
`define DEBOUNCED_KEY_REPORT_BUILDER_MACROS_SVH

// clocked check, muted while reset is asserted
`define DKR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("report builder check failed");

// clocked check that also holds through reset
`define DKR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("report builder reset check failed");

`endif

// ----- rtl/dkr_pkg.sv -----
// shared constants, types and keycode mapping for the report builder
// no dependencies
package dkr_pkg;

    localparam int DIRECT_KEYS = 9;
    localparam int NUM_KEYS    = 11;
    localparam int ENC_BTN1    = 9;
    localparam int ENC_BTN2    = 10;

    localparam logic [7:0] TICKS_RESET   = 8'd10;
    localparam logic [7:0] CODE_VOL_UP   = 8'hE9;
    localparam logic [7:0] CODE_VOL_DOWN = 8'hEA;
    localparam logic [7:0] CODE_IDLE     = 8'h00;
    localparam logic [3:0] FIRST_KEYCODE = 4'h4;
    localparam logic [3:0] BTN1_KEYCODE  = 4'hd;
    localparam logic [3:0] BTN2_KEYCODE  = 4'he;

    // per-tick control handed to the debouncer bank
    typedef struct packed {
        logic       accept;
        logic [7:0] limit;
    } t_tick_ctl;

    // encoder motion decoded from one count delta
    typedef enum logic [1:0] {
        MOT_NONE = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } t_motion;

    function automatic logic key_in_use(input int i);
        return (i < DIRECT_KEYS) || (i == ENC_BTN1) || (i == ENC_BTN2);
    endfunction

    // bit position in report bytes 1..2 for key i
    function automatic logic [3:0] keycode_of(input int i);
        logic [3:0] code;
        if (i == ENC_BTN1) begin
            code = BTN1_KEYCODE;
        end else if (i == ENC_BTN2) begin
            code = BTN2_KEYCODE;
        end else begin
            code = FIRST_KEYCODE + 4'(i);
        end
        return code;
    endfunction

endpackage

// ----- rtl/dkr_debounce.sv -----
// bank of eleven counter debouncers, updated once per accepted request
// depends on dkr_pkg
module dkr_debounce (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dkr_pkg::t_tick_ctl               i_ctl,
    input  logic [dkr_pkg::NUM_KEYS-1:0]     i_raw,
    output logic [dkr_pkg::NUM_KEYS-1:0]     o_state_next
);

    logic [dkr_pkg::NUM_KEYS-1:0] r_state;
    logic [dkr_pkg::NUM_KEYS-1:0] n_state;
    logic [7:0]                   r_count [dkr_pkg::NUM_KEYS];
    logic [7:0]                   n_count [dkr_pkg::NUM_KEYS];

    // per-key count, saturate, compare and flip
    always_comb begin
        logic [7:0] inc;
        for (int i = 0; i < dkr_pkg::NUM_KEYS; i++) begin
            inc        = (r_count[i] == 8'hFF) ? r_count[i] : r_count[i] + 8'd1;
            n_state[i] = r_state[i];
            n_count[i] = 8'd0;
            if (!dkr_pkg::key_in_use(i)) begin
                n_state[i] = 1'b0;
            end else if (i_raw[i] != r_state[i]) begin
                if (inc >= i_ctl.limit) begin
                    n_state[i] = ~r_state[i];
                end else begin
                    n_count[i] = inc;
                end
            end
        end
    end

    assign o_state_next = n_state;

    // state advances only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            for (int i = 0; i < dkr_pkg::NUM_KEYS; i++) begin
                r_count[i] <= 8'd0;
            end
        end else if (i_ctl.accept) begin
            r_state <= n_state;
            for (int i = 0; i < dkr_pkg::NUM_KEYS; i++) begin
                r_count[i] <= n_count[i];
            end
        end
    end

endmodule

// ----- rtl/dkr_encoder.sv -----
// encoder delta tracking and consumer code selection
// depends on dkr_pkg
module dkr_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [15:0] i_enc1_count,
    input  logic [15:0] i_enc2_count,
    output logic [7:0]  o_code
);

    logic [15:0]      r_last1;
    logic [15:0]      r_last2;
    logic [15:0]      delta1;
    logic [15:0]      delta2;
    dkr_pkg::t_motion mot1;
    dkr_pkg::t_motion mot2;
    dkr_pkg::t_motion mot;

    assign delta1 = i_enc1_count - r_last1;
    assign delta2 = i_enc2_count - r_last2;

    // sign of the wrapped delta gives the direction
    always_comb begin
        mot1 = (delta1 == 16'd0) ? dkr_pkg::MOT_NONE
             : (delta1[15] ? dkr_pkg::MOT_DOWN : dkr_pkg::MOT_UP);
        mot2 = (delta2 == 16'd0) ? dkr_pkg::MOT_NONE
             : (delta2[15] ? dkr_pkg::MOT_DOWN : dkr_pkg::MOT_UP);
        mot  = (mot1 != dkr_pkg::MOT_NONE) ? mot1 : mot2;
    end

    // motion to consumer code
    always_comb begin
        unique case (mot)
            dkr_pkg::MOT_UP:   o_code = dkr_pkg::CODE_VOL_UP;
            dkr_pkg::MOT_DOWN: o_code = dkr_pkg::CODE_VOL_DOWN;
            default:           o_code = dkr_pkg::CODE_IDLE;
        endcase
    end

    // last counts follow every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last1 <= 16'd0;
            r_last2 <= 16'd0;
        end else if (i_accept) begin
            r_last1 <= i_enc1_count;
            r_last2 <= i_enc2_count;
        end
    end

endmodule

// ----- rtl/debounced_key_report_builder.sv -----
// Debounced key report builder. One request per scan tick is accepted every
// cycle unless the result register is full and stalled; its result appears in
// the output register on the following cycle. All eleven debouncers, the encoder
// deltas and the report compare are one combinational pass from the held state
// into the result register. A new request is taken whenever the result register
// is empty or being drained in the same cycle. i_cfg_we writes debounce_ticks
// (reset 10, 0 behaves as 1); the user must write it only while idle, the block does not enforce this.
// depends on dkr_pkg, dkr_debounce, dkr_encoder
module debounced_key_report_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [10:0] i_raw_pressed,
    input  logic [15:0] i_enc1_count,
    input  logic [15:0] i_enc2_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_key_bytes,
    output logic        o_key_send,
    output logic [7:0]  o_consumer_code,
    output logic        o_consumer_send
);

    logic [7:0]                   r_ticks;
    logic [15:0]                  r_sent_keys;
    logic [7:0]                   r_sent_code;
    logic                         r_out_valid;
    logic [15:0]                  r_key_bytes;
    logic                         r_key_send;
    logic [7:0]                   r_code;
    logic                         r_code_send;
    logic                         accept;
    dkr_pkg::t_tick_ctl           ctl;
    logic [dkr_pkg::NUM_KEYS-1:0] state_next;
    logic [7:0]                   code;
    logic [15:0]                  keys;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign ctl.accept = accept;
    assign ctl.limit  = (r_ticks == 8'd0) ? 8'd1 : r_ticks;

    dkr_debounce u_debounce (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_raw        (i_raw_pressed),
        .o_state_next (state_next)
    );

    dkr_encoder u_encoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_enc1_count (i_enc1_count),
        .i_enc2_count (i_enc2_count),
        .o_code       (code)
    );

    // map debounced keys onto keycode bits
    always_comb begin
        keys = 16'd0;
        for (int i = 0; i < dkr_pkg::NUM_KEYS; i++) begin
            if (dkr_pkg::key_in_use(i)) begin
                keys[dkr_pkg::keycode_of(i)] = state_next[i];
            end
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= dkr_pkg::TICKS_RESET;
        end else if (i_cfg_we) begin
            r_ticks <= i_cfg_wdata;
        end
    end

    // last sent reports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_keys <= 16'd0;
            r_sent_code <= 8'd0;
        end else if (accept) begin
            r_sent_keys <= keys;
            r_sent_code <= code;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_bytes <= keys;
            r_key_send  <= (keys != r_sent_keys);
            r_code      <= code;
            r_code_send <= (code != r_sent_code);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_bytes     = r_key_bytes;
    assign o_key_send      = r_key_send;
    assign o_consumer_code = r_code;
    assign o_consumer_send = r_code_send;

endmodule

// ----- rtl/dkr_checker.sv -----
// port-level checks for the report builder, bound to the top level
// depends on dkr_pkg, debounced_key_report_builder_macros.svh and the top level ports
`include "debounced_key_report_builder_macros.svh"

module dkr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] o_key_bytes,
    input  logic        o_key_send,
    input  logic [7:0]  o_consumer_code,
    input  logic        o_consumer_send
);

    logic [15:0] r_prev_keys;
    logic [7:0]  r_prev_code;
    logic        out_accept;
    logic        out_stall;
    logic        key_diff;
    logic        code_diff;
    logic        code_legal;

    assign out_accept = o_out_valid && i_out_ready;
    assign out_stall  = o_out_valid && !i_out_ready;

    // last delivered reports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys <= 16'd0;
            r_prev_code <= 8'd0;
        end else if (out_accept) begin
            r_prev_keys <= o_key_bytes;
            r_prev_code <= o_consumer_code;
        end
    end

    // change flags and legal consumer codes
    assign key_diff   = (o_key_bytes != r_prev_keys);
    assign code_diff  = (o_consumer_code != r_prev_code);
    assign code_legal = (o_consumer_code == dkr_pkg::CODE_IDLE)
                     || (o_consumer_code == dkr_pkg::CODE_VOL_UP)
                     || (o_consumer_code == dkr_pkg::CODE_VOL_DOWN);

    `DKR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)
    `DKR_ASSERT(a_key_send, i_clk, i_rst_n, o_out_valid |-> (o_key_send == key_diff))
    `DKR_ASSERT(a_code_send, i_clk, i_rst_n, o_out_valid |-> (o_consumer_send == code_diff))
    `DKR_ASSERT(a_code_legal, i_clk, i_rst_n, o_out_valid |-> code_legal)
    `DKR_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> (o_out_valid && $stable(o_key_bytes)))

endmodule

bind debounced_key_report_builder dkr_checker u_dkr_checker (.*);

// ----- dv/tb_top.sv -----
// self-checking testbench for debounced_key_report_builder: debounce, keycode
// mapping, encoder direction and send flags, checked against a local predictor
// depends on dkr_pkg and the debounced_key_report_builder rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 150;

    // one expected report per accepted scan request
    typedef struct packed {
        logic [15:0] key_bytes;
        logic        key_send;
        logic [7:0]  consumer_code;
        logic        consumer_send;
    } t_report;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [10:0] raw_pressed = '0;
    logic [15:0] enc1_count = '0;
    logic [15:0] enc2_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] key_bytes;
    logic        key_send;
    logic [7:0]  consumer_code;
    logic        consumer_send;

    debounced_key_report_builder u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_raw_pressed   (raw_pressed),
        .i_enc1_count    (enc1_count),
        .i_enc2_count    (enc2_count),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_key_bytes     (key_bytes),
        .o_key_send      (key_send),
        .o_consumer_code (consumer_code),
        .o_consumer_send (consumer_send)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state, mirrors the block after reset and each write
    logic [7:0]  ticks_cfg;
    logic [10:0] key_state;
    logic [7:0]  key_count [dkr_pkg::NUM_KEYS];
    logic [15:0] prev_enc [2];
    logic [15:0] last_key_report;
    logic [7:0]  last_consumer;

    t_report pending_reports [$];

    // run bookkeeping
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_reqs = 0;
    int hold_off_done = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_key_changes = 0;
    int n_consumer_changes = 0;
    int fail_cnt = 0;
    int quiet_cycles = 0;
    logic [15:0] enc1_now = '0;
    logic [15:0] enc2_now = '0;

    task automatic model_reset();
        ticks_cfg = dkr_pkg::TICKS_RESET;
        key_state = '0;
        foreach (key_count[k]) key_count[k] = '0;
        prev_enc[0] = '0;
        prev_enc[1] = '0;
        last_key_report = '0;
        last_consumer = dkr_pkg::CODE_IDLE;
    endtask

    // direction of one encoder from its count delta, read as signed
    function automatic dkr_pkg::t_motion enc_motion(input logic [15:0] cur,
                                                    input logic [15:0] prev);
        logic [15:0] delta;
        delta = cur - prev;
        if (delta == 16'd0) return dkr_pkg::MOT_NONE;
        return delta[15] ? dkr_pkg::MOT_DOWN : dkr_pkg::MOT_UP;
    endfunction

    // advance the predictor by one scan tick and build the expected report
    function automatic t_report scan_tick(input logic [10:0] raw, input logic [15:0] c1,
                                          input logic [15:0] c2);
        t_report          r;
        logic [7:0]       need;
        logic [15:0]      keys;
        logic [3:0]       pos;
        logic             used;
        dkr_pkg::t_motion mot;
        logic [7:0]       code;
        need = (ticks_cfg == 8'd0) ? 8'd1 : ticks_cfg;
        keys = '0;
        for (int i = 0; i < dkr_pkg::NUM_KEYS; i++) begin
            used = (i < dkr_pkg::DIRECT_KEYS) || (i == dkr_pkg::ENC_BTN1)
                || (i == dkr_pkg::ENC_BTN2);
            if (!used) begin
                key_state[i] = 1'b0;
                key_count[i] = '0;
            end else begin
                if (raw[i] != key_state[i]) begin
                    if (key_count[i] != 8'hFF) key_count[i] = key_count[i] + 8'd1;
                    if (key_count[i] >= need) begin
                        key_state[i] = ~key_state[i];
                        key_count[i] = '0;
                    end
                end else begin
                    key_count[i] = '0;
                end
                if (key_state[i]) begin
                    pos = (i == dkr_pkg::ENC_BTN1) ? dkr_pkg::BTN1_KEYCODE :
                          (i == dkr_pkg::ENC_BTN2) ? dkr_pkg::BTN2_KEYCODE :
                          dkr_pkg::FIRST_KEYCODE + 4'(i);
                    keys[pos] = 1'b1;
                end
            end
        end
        // first encoder wins when it moved
        mot = enc_motion(c1, prev_enc[0]);
        if (mot == dkr_pkg::MOT_NONE) mot = enc_motion(c2, prev_enc[1]);
        prev_enc[0] = c1;
        prev_enc[1] = c2;
        case (mot)
            dkr_pkg::MOT_UP:   code = dkr_pkg::CODE_VOL_UP;
            dkr_pkg::MOT_DOWN: code = dkr_pkg::CODE_VOL_DOWN;
            default:           code = dkr_pkg::CODE_IDLE;
        endcase
        r.key_bytes     = keys;
        r.key_send      = (keys != last_key_report);
        r.consumer_code = code;
        r.consumer_send = (code != last_consumer);
        last_key_report = keys;
        last_consumer   = code;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // result checker, oldest expectation first
    always @(posedge clk) begin : report_checker
        t_report want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report with no request pending: key_bytes %h consumer %h",
                       key_bytes, consumer_code);
                fail_cnt++;
            end else begin
                want = pending_reports.pop_front();
                check_field("key_bytes", want.key_bytes, key_bytes);
                check_field("key_send", 16'(want.key_send), 16'(key_send));
                check_field("consumer_code", 16'(want.consumer_code), 16'(consumer_code));
                check_field("consumer_send", 16'(want.consumer_send), 16'(consumer_send));
                n_checked++;
                if (want.key_send) n_key_changes++;
                if (want.consumer_send) n_consumer_changes++;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when one is requested
    initial begin : receiver
        int held;
        forever begin
            @(negedge clk);
            if (hold_off_reqs != hold_off_done) begin
                out_ready <= 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES) begin
                    @(negedge clk);
                    held++;
                end
                hold_off_done++;
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d cycles without a handshake", quiet_cycles);
                $display("FAIL debounced_key_report_builder");
                $finish;
            end
        end
    end

    // send one scan request; entered and left at a falling edge
    task automatic send_tick(input logic [10:0] raw, input logic [15:0] c1,
                             input logic [15:0] c2);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        raw_pressed <= raw;
        enc1_count  <= c1;
        enc2_count  <= c2;
        do @(posedge clk); while (!in_ready);
        pending_reports.push_back(scan_tick(raw, c1, c2));
        n_sent++;
        @(negedge clk);
    endtask

    // encoder walk: mostly still or small steps, sometimes wide jumps
    function automatic logic [15:0] next_enc(input logic [15:0] cur);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return cur;
        if (pick < 6) return cur + 16'($urandom_range(1, 3));
        if (pick < 8) return cur - 16'($urandom_range(1, 3));
        if (pick == 8) return 16'($urandom_range(0, 65535));
        return cur + ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
    endfunction

    task automatic send_step(input logic [10:0] raw);
        enc1_now = next_enc(enc1_now);
        enc2_now = next_enc(enc2_now);
        send_tick(raw, enc1_now, enc2_now);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_ticks(input logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        ticks_cfg = value;
        @(negedge clk);
    endtask

    // encoder delta extremes and tie-break at the reset tick count
    task automatic test_encoder_extremes();
        logic [15:0] c1_seq [12];
        logic [15:0] c2_seq [12];
        c1_seq = '{16'h0000, 16'h0001, 16'h8001, 16'h0000, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
        c2_seq = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                   16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001};
        send_idle_pct = 0;
        stall_pct = 0;
        // all keys held long enough to register at the default count
        for (int k = 0; k < 12; k++) send_tick(11'h7FF, c1_seq[k], c2_seq[k]);
        enc1_now = 16'hFFFF;
        enc2_now = 16'h0001;
        wait_drained();
    endtask

    // a zero tick count flips on the first differing tick
    task automatic test_zero_ticks();
        logic [10:0] pats [6];
        pats = '{11'h000, 11'h7FF, 11'h555, 11'h2AA, 11'h200, 11'h400};
        write_ticks(8'd0);
        foreach (pats[k]) send_step(pats[k]);
        send_step(11'h000);
        wait_drained();
    endtask

    // a counter above a newly lowered count flips on the next differing tick
    task automatic test_lowered_ticks();
        write_ticks(8'd20);
        repeat (15) send_step(11'h7FF);
        write_ticks(8'd5);
        send_step(11'h7FF);
        send_step(11'h7FF);
        wait_drained();
    endtask

    // the widest count needs 255 steady ticks
    task automatic test_max_ticks();
        write_ticks(8'd255);
        send_idle_pct = 28;
        stall_pct = 28;
        repeat (256) send_step(11'h000);
        wait_drained();
    endtask

    // press/release sequences with bounce, plus short bursts of noise
    task automatic run_random_phase(input int n_items, input logic [7:0] ticks);
        logic [10:0] target;
        logic [10:0] raw;
        int          hold;
        int          sent_here;
        target = '0;
        sent_here = 0;
        write_ticks(ticks);
        while (sent_here < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_step(11'($urandom_range(0, 2047)));
                    sent_here++;
                end
            end else begin
                if ($urandom_range(0, 1)) target = 11'($urandom_range(0, 2047));
                else target = target ^ (11'd1 << $urandom_range(0, 10));
                // sometimes one tick short of registering
                hold = int'(ticks) + int'($urandom_range(0, 3)) - 1;
                if (hold < 1) hold = 1;
                for (int k = 0; k < hold; k++) begin
                    raw = target;
                    if ($urandom_range(0, 9) == 0) raw = raw ^ (11'd1 << $urandom_range(0, 10));
                    send_step(raw);
                    sent_here++;
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;
        stall_pct = 0;
        run_random_phase(50, 8'd1);
        send_idle_pct = 79;
        stall_pct = 0;
        run_random_phase(50, 8'd3);
        send_idle_pct = 0;
        stall_pct = 79;
        run_random_phase(50, 8'd2);
        send_idle_pct = 28;
        stall_pct = 28;
        run_random_phase(50, 8'd4);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        write_ticks(8'd2);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_reqs++;
        repeat (20) send_step(11'($urandom_range(0, 2047)));
        wait_drained();
    endtask

    initial begin : main_seq
        int waited;
        model_reset();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_encoder_extremes();
        test_zero_ticks();
        test_lowered_ticks();
        test_max_ticks();
        test_idle_phases();
        test_backpressure();

        // drain and let the pipeline settle
        in_valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
        if (pending_reports.size() != 0) begin
            $error("%0d expected reports never arrived", pending_reports.size());
            fail_cnt++;
        end

        $display("run: %0d scan requests, %0d reports checked, %0d key and %0d consumer changes",
                 n_sent, n_checked, n_key_changes, n_consumer_changes);
        $display("tick counts 0 to 255 incl. a lowered count, four idle mixes and a long hold-off");
        if (fail_cnt == 0) begin
            $display("PASS debounced_key_report_builder");
        end else begin
            $display("FAIL debounced_key_report_builder");
        end
        $finish;
    end

endmodule
